// ===== sv/oefr_pkg.sv =====
`default_nettype none

package oefr_pkg;

    // sequencer steps
    typedef enum logic [3:0] {
        SQ_IDLE,
        SQ_SUMSQ,
        SQ_ROOT,
        SQ_DECIDE,
        SQ_NORM,
        SQ_LOGSQ,
        SQ_YMUL,
        SQ_SERIES,
        SQ_SDIV_GO,
        SQ_SDIV_WAIT,
        SQ_FDIV_GO,
        SQ_FDIV_WAIT,
        SQ_TRIPCHK,
        SQ_DONE
    } seq_state_t;

    typedef enum logic [1:0] {
        RS_IDLE,
        RS_PICKUP,
        RS_TRIPPED,
        RS_LOCKOUT
    } relay_state_t;

    typedef enum logic [2:0] {
        STG_NONE,
        STG_PHASE_INST,
        STG_PHASE_IDMT,
        STG_EARTH_INST,
        STG_EARTH_IDMT
    } stage_t;

    localparam logic OP_TICK  = 1'b0;
    localparam logic OP_RESET = 1'b1;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 20;
    localparam logic [CFG_IDX_W-1:0] REG_PHASE_PICKUP = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_TIME_MULT    = 1'b1;

    localparam int PICKUP_W = 20;
    localparam int TMULT_W  = 14;
    localparam int STATE_W  = 2;
    localparam int STAGE_W  = 3;
    localparam int DELAY_W  = 17;

    localparam logic [PICKUP_W-1:0] PICKUP_RESET = 20'd4000;
    localparam logic [TMULT_W-1:0]  TMULT_RESET  = 14'd1000;
    localparam logic [DELAY_W-1:0]  DELAY_MAX    = 17'd99999;

    // shared multiplier and series arithmetic
    localparam int MUL_W  = 32;
    localparam int FRAC_W = 16;
    localparam int MANT_W = 31;
    localparam int SUM_W  = 33;
    localparam int LOG_SQ_STEPS = 16;
    localparam int SERIES_TERMS = 7;
    localparam logic [MUL_W-1:0] EXP_K = 32'd59540889;

    // shared divider
    localparam int DIV_NUM_W = 50;
    localparam int DIV_DEN_W = 40;

endpackage

`default_nettype wire

// ===== sv/oefr_if.sv =====
`default_nettype none

interface oefr_tick_if #(
    parameter int TIME_WIDTH    = 32,
    parameter int CURRENT_WIDTH = 20
);
    logic                     valid;
    logic                     ready;
    logic                     operation;
    logic [TIME_WIDTH-1:0]    time_ms;
    logic [CURRENT_WIDTH-1:0] phase_a_current;
    logic [CURRENT_WIDTH-1:0] phase_b_current;
    logic [CURRENT_WIDTH-1:0] phase_c_current;

    modport source (output valid, operation, time_ms, phase_a_current, phase_b_current,
                    phase_c_current, input ready);
    modport sink (input valid, operation, time_ms, phase_a_current, phase_b_current,
                  phase_c_current, output ready);
endinterface

interface oefr_result_if #(
    parameter int CURRENT_WIDTH = 20
);
    import oefr_pkg::*;

    logic                     valid;
    logic                     ready;
    logic                     trip_out;
    logic [STATE_W-1:0]       relay_state;
    logic [STAGE_W-1:0]       active_stage;
    logic [DELAY_W-1:0]       trip_delay_ms;
    logic [CURRENT_WIDTH-1:0] residual_current;

    modport source (output valid, trip_out, relay_state, active_stage, trip_delay_ms,
                    residual_current, input ready);
    modport sink (input valid, trip_out, relay_state, active_stage, trip_delay_ms,
                  residual_current, output ready);
endinterface

interface oefr_cfg_if;
    import oefr_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== sv/overcurrent_earth_fault_relay.sv =====
`default_nettype none

// channel  | dir | handshake     | payload
// ---------+-----+---------------+---------------------------------------------------
// tick     | in  | valid / ready | operation, time_ms, phase_a/b/c_current
// result   | out | valid / ready | trip_out, relay_state, active_stage,
//          |     |               | trip_delay_ms, residual_current
// cfg      | in  | valid / ready | index (0 phase_pickup, 1 time_multiplier), data
//
// one request at a time; tick.ready is high only while the sequencer is idle
// a reset request goes straight to the done state; a tick forms the residual by a sum of
// squares and a square root, and an idmt evaluation adds the log by squaring and the
// shared 50-bit divider (six series terms and the final quotient)
// one 32x32 multiplier is shared by the sum of squares, the log squarings, the y product and the series
// the result sits in an output register; the next tick is taken while it waits
// cfg is always ready; rst_n clears relay state and loads register defaults

module overcurrent_earth_fault_relay #(
    parameter int TIME_WIDTH    = 32,
    parameter int CURRENT_WIDTH = 20
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    oefr_tick_if.sink   tick,
    oefr_result_if.source result,
    oefr_cfg_if.sink    cfg
);
    import oefr_pkg::*;

    localparam int CW   = CURRENT_WIDTH;
    localparam int QW   = 2 * CW;
    localparam int LW   = (CW + 3 > PICKUP_W) ? CW + 3 : PICKUP_W;
    localparam int EW   = $clog2(LW);
    localparam int LOGW = EW + FRAC_W;
    localparam int CNT_W = $clog2(LW + 1);
    localparam int CMPW = LW + 4;
    localparam int ELW  = (TIME_WIDTH > DELAY_W) ? TIME_WIDTH : DELAY_W;

    // sequencer and relay state
    seq_state_t          seq_reg, seq_next;
    relay_state_t        prot_reg, prot_next;
    stage_t              stage_reg, stage_next;
    logic                trip_reg, trip_next;
    logic [TIME_WIDTH-1:0] start_reg, start_next;
    logic [PICKUP_W-1:0] pickup_reg, pickup_next;
    logic [TMULT_W-1:0]  tmult_reg, tmult_next;
    logic                ovalid_reg, ovalid_next;

    // working registers
    logic [CW-1:0]       a_reg, a_next, b_reg, b_next, c_reg, c_next;
    logic [TIME_WIDTH-1:0] now_reg, now_next;
    logic [QW-1:0]       acc_reg, acc_next;
    logic [CW:0]         rem_reg, rem_next;
    logic [CW-1:0]       root_reg, root_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [2:0]          k_reg, k_next;
    logic [LW-1:0]       lx_reg, lx_next;
    logic [EW-1:0]       e_reg, e_next;
    logic [MANT_W-1:0]   m_reg, m_next;
    logic [FRAC_W-1:0]   f_reg, f_next;
    logic [LOGW-1:0]     lc_reg, lc_next;
    logic                lsel_reg, lsel_next;
    logic [MUL_W-1:0]    y_reg, y_next;
    logic [MUL_W-1:0]    term_reg, term_next;
    logic [SUM_W-1:0]    d_reg, d_next;
    logic [DELAY_W-1:0]  delay_reg, delay_next;

    // output register
    logic                otrip_reg, otrip_next;
    relay_state_t        ostate_reg, ostate_next;
    stage_t              ostage_reg, ostage_next;
    logic [DELAY_W-1:0]  odelay_reg, odelay_next;
    logic [CW-1:0]       ores_reg, ores_next;

    // shared units
    logic [MUL_W-1:0]     mul_a, mul_b;
    logic [2*MUL_W-1:0]   mul_p;
    logic                 div_start, div_done;
    logic [DIV_NUM_W-1:0] div_num, div_quo;
    logic [DIV_DEN_W-1:0] div_den;

    // combinational helpers
    logic [CW+1:0]        rem_t, trial;
    logic [CMPW-1:0]      five_r, p_ext, mx_ext, cur_ext;
    logic [CW-1:0]        mx;
    logic [TIME_WIDTH-1:0] elapsed;
    logic [LW+MANT_W-1:0] norm_wide;
    logic [MANT_W:0]      sq;
    logic [FRAC_W-1:0]    f_new;
    logic [LOGW-1:0]      lval;
    logic [TMULT_W+3:0]   tm14;
    logic [DIV_DEN_W-1:0] d_ext;

    assign mul_p = (2*MUL_W)'(mul_a) * (2*MUL_W)'(mul_b);

    oefr_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quo   (div_quo)
    );

    assign tick.ready = (seq_reg == SQ_IDLE);
    assign cfg.ready  = 1'b1;

    assign result.valid            = ovalid_reg;
    assign result.trip_out         = otrip_reg;
    assign result.relay_state      = ostate_reg;
    assign result.active_stage     = ostage_reg;
    assign result.trip_delay_ms    = odelay_reg;
    assign result.residual_current = ores_reg;

    always_comb
    begin
        seq_next    = seq_reg;
        prot_next   = prot_reg;
        stage_next  = stage_reg;
        trip_next   = trip_reg;
        start_next  = start_reg;
        pickup_next = pickup_reg;
        tmult_next  = tmult_reg;
        ovalid_next = ovalid_reg;
        a_next      = a_reg;
        b_next      = b_reg;
        c_next      = c_reg;
        now_next    = now_reg;
        acc_next    = acc_reg;
        rem_next    = rem_reg;
        root_next   = root_reg;
        cnt_next    = cnt_reg;
        k_next      = k_reg;
        lx_next     = lx_reg;
        e_next      = e_reg;
        m_next      = m_reg;
        f_next      = f_reg;
        lc_next     = lc_reg;
        lsel_next   = lsel_reg;
        y_next      = y_reg;
        term_next   = term_reg;
        d_next      = d_reg;
        delay_next  = delay_reg;
        otrip_next  = otrip_reg;
        ostate_next = ostate_reg;
        ostage_next = ostage_reg;
        odelay_next = odelay_reg;
        ores_next   = ores_reg;
        mul_a       = '0;
        mul_b       = '0;
        div_start   = 1'b0;
        div_num     = '0;
        div_den     = '0;

        // digit-serial square root step
        rem_t = {rem_reg[CW-1:0], acc_reg[QW-1 -: 2]};
        trial = {root_reg, 2'b01};

        // decision values
        five_r  = (CMPW'(root_reg) << 2) + CMPW'(root_reg);
        p_ext   = CMPW'(pickup_reg);
        mx      = (a_reg > b_reg) ? a_reg : b_reg;
        if (c_reg > mx)
        begin
            mx = c_reg;
        end
        mx_ext  = CMPW'(mx);
        cur_ext = (stage_reg == STG_EARTH_IDMT) ? five_r : mx_ext;
        elapsed = now_reg - start_reg;

        // log2 mantissa: top bits of the normalized word, then squaring
        norm_wide = {lx_reg, {MANT_W{1'b0}}};
        sq        = mul_p[2*MANT_W-1 -: MANT_W+1];
        f_new     = {f_reg[FRAC_W-2:0], sq[MANT_W]};
        lval      = {e_reg, f_new};

        tm14  = (TMULT_W+4)'(tmult_reg) * 18'd0 + ((TMULT_W+4)'(tmult_reg) << 4)
                - ((TMULT_W+4)'(tmult_reg) << 1);
        d_ext = (DIV_DEN_W'(d_reg) << 6) + (DIV_DEN_W'(d_reg) << 5) + (DIV_DEN_W'(d_reg) << 2);

        if (result.ready)
        begin
            ovalid_next = 1'b0;
        end

        // configuration writes
        if (cfg.valid)
        begin
            case (cfg.index)
                REG_PHASE_PICKUP: pickup_next = cfg.data;
                REG_TIME_MULT:    tmult_next  = cfg.data[TMULT_W-1:0];
                default:          ;
            endcase
        end

        case (seq_reg)
            SQ_IDLE:
            begin
                if (tick.valid)
                begin
                    a_next   = tick.phase_a_current;
                    b_next   = tick.phase_b_current;
                    c_next   = tick.phase_c_current;
                    now_next = tick.time_ms;
                    if (tick.operation == OP_RESET)
                    begin
                        prot_next  = RS_IDLE;
                        stage_next = STG_NONE;
                        trip_next  = 1'b0;
                        root_next  = '0;
                        delay_next = '0;
                        seq_next   = SQ_DONE;
                    end
                    else
                    begin
                        acc_next = '0;
                        k_next   = '0;
                        seq_next = SQ_SUMSQ;
                    end
                end
            end

            // q = a^2 + b^2 + c^2 - ab - bc - ca, one product per cycle
            SQ_SUMSQ:
            begin
                case (k_reg)
                    3'd0:
                    begin
                        mul_a = MUL_W'(a_reg);
                        mul_b = MUL_W'(a_reg);
                    end
                    3'd1:
                    begin
                        mul_a = MUL_W'(b_reg);
                        mul_b = MUL_W'(b_reg);
                    end
                    3'd2:
                    begin
                        mul_a = MUL_W'(c_reg);
                        mul_b = MUL_W'(c_reg);
                    end
                    3'd3:
                    begin
                        mul_a = MUL_W'(a_reg);
                        mul_b = MUL_W'(b_reg);
                    end
                    3'd4:
                    begin
                        mul_a = MUL_W'(b_reg);
                        mul_b = MUL_W'(c_reg);
                    end
                    default:
                    begin
                        mul_a = MUL_W'(c_reg);
                        mul_b = MUL_W'(a_reg);
                    end
                endcase
                if (k_reg < 3'd3)
                begin
                    acc_next = acc_reg + QW'(mul_p);
                end
                else
                begin
                    acc_next = acc_reg - QW'(mul_p);
                end
                if (k_reg == 3'd5)
                begin
                    rem_next  = '0;
                    root_next = '0;
                    cnt_next  = '0;
                    seq_next  = SQ_ROOT;
                end
                else
                begin
                    k_next = k_reg + 1'b1;
                end
            end

            SQ_ROOT:
            begin
                if (rem_t >= trial)
                begin
                    rem_next  = CW'(rem_t - trial);
                    root_next = {root_reg[CW-2:0], 1'b1};
                end
                else
                begin
                    rem_next  = rem_t[CW:0];
                    root_next = {root_reg[CW-2:0], 1'b0};
                end
                acc_next = acc_reg << 2;
                if (cnt_reg == CNT_W'(CW - 1))
                begin
                    seq_next = SQ_DECIDE;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end

            SQ_DECIDE:
            begin
                delay_next = '0;
                seq_next   = SQ_DONE;
                case (prot_reg)
                    RS_IDLE:
                    begin
                        // earth fault has priority over phase fault
                        if (five_r > p_ext)
                        begin
                            stage_next = (CMPW'(root_reg) > (p_ext << 1)) ?
                                         STG_EARTH_INST : STG_EARTH_IDMT;
                            prot_next  = RS_PICKUP;
                            start_next = now_reg;
                        end
                        else if (mx_ext > p_ext)
                        begin
                            stage_next = (mx_ext > ((p_ext << 3) + (p_ext << 1))) ?
                                         STG_PHASE_INST : STG_PHASE_IDMT;
                            prot_next  = RS_PICKUP;
                            start_next = now_reg;
                        end
                    end
                    RS_PICKUP:
                    begin
                        if (stage_reg == STG_PHASE_INST || stage_reg == STG_EARTH_INST)
                        begin
                            seq_next = SQ_TRIPCHK;
                        end
                        else if (cur_ext <= p_ext)
                        begin
                            delay_next = DELAY_MAX;
                            seq_next   = SQ_TRIPCHK;
                        end
                        else
                        begin
                            lx_next   = cur_ext[LW-1:0];
                            e_next    = EW'(LW - 1);
                            lsel_next = 1'b0;
                            seq_next  = SQ_NORM;
                        end
                    end
                    RS_TRIPPED:
                    begin
                        prot_next = RS_LOCKOUT;
                    end
                    default:
                    begin
                    end
                endcase
            end

            // shift left until the msb is set, tracking the exponent
            SQ_NORM:
            begin
                if (lx_reg[LW-1])
                begin
                    m_next   = norm_wide[LW+MANT_W-1 -: MANT_W];
                    f_next   = '0;
                    cnt_next = '0;
                    seq_next = SQ_LOGSQ;
                end
                else
                begin
                    lx_next = lx_reg << 1;
                    e_next  = e_reg - 1'b1;
                end
            end

            // one fraction bit per squaring of the mantissa
            SQ_LOGSQ:
            begin
                mul_a  = MUL_W'(m_reg);
                mul_b  = MUL_W'(m_reg);
                f_next = f_new;
                if (sq[MANT_W])
                begin
                    m_next = sq[MANT_W:1];
                end
                else
                begin
                    m_next = sq[MANT_W-1:0];
                end
                if (cnt_reg == CNT_W'(LOG_SQ_STEPS - 1))
                begin
                    if (!lsel_reg)
                    begin
                        lc_next   = lval;
                        lx_next   = (pickup_reg == '0) ? LW'(1) : LW'(pickup_reg);
                        e_next    = EW'(LW - 1);
                        lsel_next = 1'b1;
                        seq_next  = SQ_NORM;
                    end
                    else if (lc_reg <= lval)
                    begin
                        delay_next = DELAY_MAX;
                        seq_next   = SQ_TRIPCHK;
                    end
                    else
                    begin
                        lc_next  = lc_reg - lval;
                        seq_next = SQ_YMUL;
                    end
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end

            // y = L * 0.02 ln2 in Q32
            SQ_YMUL:
            begin
                mul_a     = MUL_W'(lc_reg);
                mul_b     = EXP_K;
                y_next    = mul_p[MUL_W+FRAC_W-1:FRAC_W];
                term_next = mul_p[MUL_W+FRAC_W-1:FRAC_W];
                d_next    = '0;
                k_next    = 3'd1;
                seq_next  = SQ_SERIES;
            end

            // exp(y) - 1 series, next term = term * y / (k + 1)
            SQ_SERIES:
            begin
                d_next = d_reg + SUM_W'(term_reg);
                if (k_reg == 3'(SERIES_TERMS))
                begin
                    seq_next = SQ_FDIV_GO;
                end
                else
                begin
                    mul_a     = term_reg;
                    mul_b     = y_reg;
                    term_next = mul_p[2*MUL_W-1:MUL_W];
                    seq_next  = SQ_SDIV_GO;
                end
            end

            SQ_SDIV_GO:
            begin
                div_start = 1'b1;
                div_num   = DIV_NUM_W'(term_reg);
                div_den   = DIV_DEN_W'(k_reg) + 1'b1;
                seq_next  = SQ_SDIV_WAIT;
            end

            SQ_SDIV_WAIT:
            begin
                if (div_done)
                begin
                    term_next = div_quo[MUL_W-1:0];
                    k_next    = k_reg + 1'b1;
                    seq_next  = SQ_SERIES;
                end
            end

            // delay = tm * 14 * 2^32 / (100 * d)
            SQ_FDIV_GO:
            begin
                if (d_reg == '0)
                begin
                    delay_next = DELAY_MAX;
                    seq_next   = SQ_TRIPCHK;
                end
                else
                begin
                    div_start = 1'b1;
                    div_num   = {tm14, {(DIV_NUM_W-TMULT_W-4){1'b0}}};
                    div_den   = d_ext;
                    seq_next  = SQ_FDIV_WAIT;
                end
            end

            SQ_FDIV_WAIT:
            begin
                if (div_done)
                begin
                    delay_next = (div_quo > DIV_NUM_W'(DELAY_MAX)) ? DELAY_MAX :
                                 div_quo[DELAY_W-1:0];
                    seq_next   = SQ_TRIPCHK;
                end
            end

            SQ_TRIPCHK:
            begin
                if (ELW'(elapsed) >= ELW'(delay_reg))
                begin
                    trip_next  = 1'b1;
                    prot_next  = RS_TRIPPED;
                    start_next = now_reg;
                end
                seq_next = SQ_DONE;
            end

            SQ_DONE:
            begin
                if (!ovalid_reg || result.ready)
                begin
                    otrip_next  = trip_reg;
                    ostate_next = prot_reg;
                    ostage_next = stage_reg;
                    odelay_next = delay_reg;
                    ores_next   = root_reg;
                    ovalid_next = 1'b1;
                    seq_next    = SQ_IDLE;
                end
            end

            default:
            begin
                seq_next = SQ_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_reg    <= SQ_IDLE;
            prot_reg   <= RS_IDLE;
            stage_reg  <= STG_NONE;
            trip_reg   <= 1'b0;
            start_reg  <= '0;
            pickup_reg <= PICKUP_RESET;
            tmult_reg  <= TMULT_RESET;
            ovalid_reg <= 1'b0;
            cnt_reg    <= '0;
            k_reg      <= '0;
            lsel_reg   <= 1'b0;
        end
        else
        begin
            seq_reg    <= seq_next;
            prot_reg   <= prot_next;
            stage_reg  <= stage_next;
            trip_reg   <= trip_next;
            start_reg  <= start_next;
            pickup_reg <= pickup_next;
            tmult_reg  <= tmult_next;
            ovalid_reg <= ovalid_next;
            cnt_reg    <= cnt_next;
            k_reg      <= k_next;
            lsel_reg   <= lsel_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg      <= a_next;
        b_reg      <= b_next;
        c_reg      <= c_next;
        now_reg    <= now_next;
        acc_reg    <= acc_next;
        rem_reg    <= rem_next;
        root_reg   <= root_next;
        lx_reg     <= lx_next;
        e_reg      <= e_next;
        m_reg      <= m_next;
        f_reg      <= f_next;
        lc_reg     <= lc_next;
        y_reg      <= y_next;
        term_reg   <= term_next;
        d_reg      <= d_next;
        delay_reg  <= delay_next;
        otrip_reg  <= otrip_next;
        ostate_reg <= ostate_next;
        ostage_reg <= ostage_next;
        odelay_reg <= odelay_next;
        ores_reg   <= ores_next;
    end

endmodule

`default_nettype wire

// ===== sv/oefr_div.sv =====
`default_nettype none

module oefr_div (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           start,
    input  wire logic [oefr_pkg::DIV_NUM_W-1:0] num,
    input  wire logic [oefr_pkg::DIV_DEN_W-1:0] den,
    output logic                                done,
    output logic [oefr_pkg::DIV_NUM_W-1:0]      quo
);
    import oefr_pkg::*;

    localparam int CNT_W = $clog2(DIV_NUM_W + 1);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic [DIV_DEN_W:0]   rem_reg, rem_next;
    logic [DIV_NUM_W-1:0] quo_reg, quo_next;
    logic [DIV_DEN_W-1:0] den_reg, den_next;
    logic [DIV_DEN_W:0]   rem_sh;

    // restoring division, one quotient bit per cycle
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        rem_sh    = {rem_reg[DIV_DEN_W-1:0], quo_reg[DIV_NUM_W-1]};
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            quo_next  = num;
            den_next  = den;
        end
        else if (busy_reg)
        begin
            if (rem_sh >= {1'b0, den_reg})
            begin
                rem_next = rem_sh - {1'b0, den_reg};
                quo_next = {quo_reg[DIV_NUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = rem_sh;
                quo_next = {quo_reg[DIV_NUM_W-2:0], 1'b0};
            end
            if (cnt_reg == CNT_W'(DIV_NUM_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule

`default_nettype wire

// ===== tb/sv/overcurrent_earth_fault_relay_test.sv =====
`timescale 1ns / 100ps

module overcurrent_earth_fault_relay_test;
    import oefr_pkg::*;

    localparam logic [19:0] CUR_TOP    = 20'hFFFFF;
    localparam int          SETTLE_CYC = 700;    // worst idmt evaluation plus margin
    localparam int          STALL_LIMIT = 20000; // cycles with no handshake at all

    typedef struct {
        logic        op;
        logic [31:0] t_ms;
        logic [19:0] ia;
        logic [19:0] ib;
        logic [19:0] ic;
    } tick_req_t;

    typedef struct {
        logic         trip;
        relay_state_t state;
        stage_t       stage;
        logic [16:0]  delay;
        logic [19:0]  resid;
    } relay_out_t;

    logic clk;
    logic rst_n;

    oefr_tick_if #(.TIME_WIDTH(32), .CURRENT_WIDTH(20)) tick_ch ();
    oefr_result_if #(.CURRENT_WIDTH(20)) res_ch ();
    oefr_cfg_if cfg_ch ();

    overcurrent_earth_fault_relay #(.TIME_WIDTH(32), .CURRENT_WIDTH(20)) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .tick   (tick_ch),
        .result (res_ch),
        .cfg    (cfg_ch)
    );

    // 12 ns clock
    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    // pending requests and expected relay outputs
    tick_req_t  tick_queue[$];
    relay_out_t relay_expected[$];

    // predictor copy of relay state and settings
    relay_state_t prot_state;
    stage_t       prot_stage;
    logic [31:0]  pickup_t0;
    logic         trip_held;
    logic [19:0]  pickup_set;
    logic [13:0]  tmult_set;

    // stimulus bookkeeping
    logic [19:0] gen_pickup;
    logic [31:0] gen_now;
    logic        hold_tx;
    logic        tick_taken;
    int          tick_gap;
    int          rdy_gap;
    int          idle_cycles;
    int          n_ticks;
    int          n_results;
    int          n_trips;
    int          n_cfg;
    int          n_errors;

    // random gap: mostly none or short, now and then long
    function automatic int pick_gap();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 55)
            return 0;
        else if (sel < 88)
            return $urandom_range(1, 3);
        else if (sel < 98)
            return $urandom_range(4, 20);
        return $urandom_range(50, 200);
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned root;
        longint unsigned b;
        root = 0;
        b = 64'h4000_0000_0000_0000;
        while (b > v)
            b >>= 2;
        while (b != 0)
        begin
            if (v >= root + b)
            begin
                v -= root + b;
                root = (root >> 1) + b;
            end
            else
                root >>= 1;
            b >>= 2;
        end
        return root;
    endfunction

    // log2 in q16: msb index plus 16 fraction bits by repeated squaring
    function automatic longint unsigned log2_q16(longint unsigned x);
        int              e;
        longint unsigned m;
        longint unsigned f;
        f = 0;
        e = 63;
        if (x == 0)
            x = 1;
        while (x[e] == 1'b0)
            e--;
        m = (e <= 30) ? (x << (30 - e)) : (x >> (e - 30));
        for (int i = 0; i < 16; i++)
        begin
            m = (m * m) >> 30;
            f <<= 1;
            if (m >= (64'd2 << 30))
            begin
                m >>= 1;
                f |= 1;
            end
        end
        return (longint'(e) << 16) | f;
    endfunction

    // iec standard inverse operate time in ms, saturated
    function automatic longint unsigned inverse_time_ms(longint unsigned cur,
                                                        longint unsigned pick,
                                                        longint unsigned tm);
        longint unsigned lc;
        longint unsigned lp;
        longint unsigned y;
        longint unsigned term;
        longint unsigned d;
        longint unsigned t;
        if (cur <= pick)
            return DELAY_MAX;
        lc = log2_q16(cur);
        lp = log2_q16(pick);
        if (lc <= lp)
            return DELAY_MAX;
        y = ((lc - lp) * 64'(EXP_K)) >> 16;
        term = y;
        d = 0;
        // e^y - 1 by truncated series
        for (int k = 1; k <= 7; k++)
        begin
            d += term;
            term = ((term * y) >> 32) / (k + 1);
        end
        if (d == 0)
            return DELAY_MAX;
        t = ((tm * 14) << 32) / (100 * d);
        return (t > DELAY_MAX) ? DELAY_MAX : t;
    endfunction

    // advance the relay copy by one accepted request
    function automatic relay_out_t relay_step(tick_req_t rq);
        relay_out_t      o;
        longint unsigned a;
        longint unsigned b;
        longint unsigned c;
        longint unsigned r;
        longint unsigned mx;
        longint unsigned p;
        longint unsigned dly;
        logic [31:0]     elapsed;
        a = rq.ia;
        b = rq.ib;
        c = rq.ic;
        p = pickup_set;
        dly = 0;
        if (rq.op == OP_RESET)
        begin
            prot_state = RS_IDLE;
            prot_stage = STG_NONE;
            trip_held = 1'b0;
            o.trip = 1'b0;
            o.state = RS_IDLE;
            o.stage = STG_NONE;
            o.delay = '0;
            o.resid = '0;
            return o;
        end
        r = int_sqrt(a * a + b * b + c * c - a * b - b * c - c * a);
        mx = (a > b) ? a : b;
        if (c > mx)
            mx = c;
        elapsed = rq.t_ms - pickup_t0;
        case (prot_state)
            RS_IDLE:
            begin
                // earth fault has priority over phase fault
                if (5 * r > p)
                begin
                    prot_stage = (r > 2 * p) ? STG_EARTH_INST : STG_EARTH_IDMT;
                    prot_state = RS_PICKUP;
                    pickup_t0 = rq.t_ms;
                end
                else if (mx > p)
                begin
                    prot_stage = (mx > 10 * p) ? STG_PHASE_INST : STG_PHASE_IDMT;
                    prot_state = RS_PICKUP;
                    pickup_t0 = rq.t_ms;
                end
            end
            RS_PICKUP:
            begin
                if (prot_stage == STG_PHASE_INST || prot_stage == STG_EARTH_INST)
                    dly = 0;
                else if (prot_stage == STG_EARTH_IDMT)
                    dly = inverse_time_ms(5 * r, p, tmult_set);
                else
                    dly = inverse_time_ms(mx, p, tmult_set);
                if (64'(elapsed) >= dly)
                begin
                    trip_held = 1'b1;
                    prot_state = RS_TRIPPED;
                    pickup_t0 = rq.t_ms;
                end
            end
            RS_TRIPPED:
                prot_state = RS_LOCKOUT;
            default:
                ;
        endcase
        o.trip = trip_held;
        o.state = prot_state;
        o.stage = prot_stage;
        o.delay = dly[16:0];
        o.resid = r[19:0];
        return o;
    endfunction

    task automatic report_mismatch(string field, longint unsigned got, longint unsigned want);
        $display("error: result %0d field %s got %0d want %0d", n_results, field, got, want);
        n_errors++;
    endtask

    // reset and input defaults
    initial
    begin
        rst_n = 1'b0;
        tick_ch.valid = 1'b0;
        tick_ch.operation = OP_TICK;
        tick_ch.time_ms = '0;
        tick_ch.phase_a_current = '0;
        tick_ch.phase_b_current = '0;
        tick_ch.phase_c_current = '0;
        res_ch.ready = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = REG_PHASE_PICKUP;
        cfg_ch.data = '0;
        repeat (2) @(negedge clk);
        rst_n = 1'b1;
    end

    // request driver: holds the request until taken, then the next after a gap
    always @(negedge clk)
    begin
        tick_req_t rq;
        if (!rst_n)
            tick_ch.valid <= 1'b0;
        else if (tick_ch.valid && !tick_taken)
            ;
        else if (tick_gap > 0 || hold_tx || tick_queue.size() == 0)
        begin
            tick_ch.valid <= 1'b0;
            if (tick_gap > 0)
                tick_gap <= tick_gap - 1;
        end
        else
        begin
            rq = tick_queue.pop_front();
            tick_ch.operation <= rq.op;
            tick_ch.time_ms <= rq.t_ms;
            tick_ch.phase_a_current <= rq.ia;
            tick_ch.phase_b_current <= rq.ib;
            tick_ch.phase_c_current <= rq.ic;
            tick_ch.valid <= 1'b1;
            tick_gap <= pick_gap();
        end
    end

    // result side back-pressure
    always @(negedge clk)
    begin
        if (rdy_gap > 0)
        begin
            res_ch.ready <= 1'b0;
            rdy_gap <= rdy_gap - 1;
        end
        else
        begin
            res_ch.ready <= rst_n;
            if ($urandom_range(0, 4) == 0)
                rdy_gap <= pick_gap();
        end
    end

    // monitor: predict on accepted requests, check accepted results
    always @(posedge clk)
    begin
        tick_req_t  rq;
        relay_out_t want;
        tick_taken <= tick_ch.valid && tick_ch.ready;
        if (rst_n && cfg_ch.valid && cfg_ch.ready)
        begin
            if (cfg_ch.index == REG_PHASE_PICKUP)
                pickup_set = cfg_ch.data[19:0];
            else if (cfg_ch.index == REG_TIME_MULT)
                tmult_set = cfg_ch.data[13:0];
            n_cfg++;
        end
        if (rst_n && tick_ch.valid && tick_ch.ready)
        begin
            rq.op = tick_ch.operation;
            rq.t_ms = tick_ch.time_ms;
            rq.ia = tick_ch.phase_a_current;
            rq.ib = tick_ch.phase_b_current;
            rq.ic = tick_ch.phase_c_current;
            relay_expected.push_back(relay_step(rq));
            n_ticks++;
        end
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            n_results++;
            if (relay_expected.size() == 0)
            begin
                $display("error: unexpected result %0d", n_results);
                n_errors++;
            end
            else
            begin
                want = relay_expected.pop_front();
                if (res_ch.trip_out !== want.trip)
                    report_mismatch("trip_out", res_ch.trip_out, want.trip);
                if (res_ch.relay_state !== want.state)
                    report_mismatch("relay_state", res_ch.relay_state, want.state);
                if (res_ch.active_stage !== want.stage)
                    report_mismatch("active_stage", res_ch.active_stage, want.stage);
                if (res_ch.trip_delay_ms !== want.delay)
                    report_mismatch("trip_delay_ms", res_ch.trip_delay_ms, want.delay);
                if (res_ch.residual_current !== want.resid)
                    report_mismatch("residual_current", res_ch.residual_current,
                                    want.resid);
                if (want.trip && want.state == RS_TRIPPED)
                    n_trips++;
            end
        end
    end

    // watchdog on cycles without any handshake
    always @(posedge clk)
    begin
        if ((tick_ch.valid && tick_ch.ready) || (res_ch.valid && res_ch.ready)
            || (cfg_ch.valid && cfg_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("timeout after %0d quiet cycles", idle_cycles);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    function automatic logic [19:0] clip_cur(longint unsigned v);
        return (v > CUR_TOP) ? CUR_TOP : v[19:0];
    endfunction

    task automatic push_tick(logic op, logic [31:0] t, logic [19:0] a, logic [19:0] b,
                             logic [19:0] c);
        tick_req_t rq;
        rq.op = op;
        rq.t_ms = t;
        rq.ia = a;
        rq.ib = b;
        rq.ic = c;
        tick_queue.push_back(rq);
    endtask

    // wait until nothing is queued or pending, then let the sequencer finish
    task automatic drain();
        while (tick_queue.size() != 0 || tick_ch.valid || relay_expected.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYC) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [19:0] val);
        @(negedge clk);
        cfg_ch.index <= idx;
        cfg_ch.data <= val;
        cfg_ch.valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
        if (idx == REG_PHASE_PICKUP)
            gen_pickup = val;
    endtask

    // one fault scenario: reset, then ticks with a chosen fault kind and time steps
    task automatic fault_scenario();
        int              kind;
        int              nt;
        longint unsigned p;
        longint unsigned lvl;
        longint unsigned step;
        p = gen_pickup;
        kind = $urandom_range(0, 5);
        nt = $urandom_range(2, 8);
        // sometimes start close to the time counter wrap
        if ($urandom_range(0, 7) == 0)
            gen_now = 32'hFFFF_FFFF - $urandom_range(0, 30000);
        push_tick(OP_RESET, $urandom, $urandom, $urandom, $urandom);
        for (int i = 0; i < nt; i++)
        begin
            case (kind)
                0: lvl = $urandom_range(0, 1) ? p / 5 + 1 + $urandom_range(0, 10)
                                              : p / 5 + $urandom_range(0, 32'(2 * p));
                1: lvl = 2 * p + 1 + $urandom_range(0, 32'(p));
                2: lvl = p + 1 + $urandom_range(0, 32'(9 * p));
                3: lvl = 10 * p + $urandom_range(1, 1000);
                4: lvl = p - ((p > 0) ? $urandom_range(0, 32'(p)) : 0);
                default: lvl = $urandom_range(0, 32'(3 * p + 10));
            endcase
            if (kind <= 1)
                // one phase only: residual equals that current
                push_tick(OP_TICK, gen_now, 20'd0, clip_cur(lvl), 20'd0);
            else if (kind == 5)
                push_tick(OP_TICK, gen_now, clip_cur(lvl), clip_cur($urandom_range(0,
                          32'(lvl))), clip_cur(lvl / 2));
            else
                // balanced phases give no residual
                push_tick(OP_TICK, gen_now, clip_cur(lvl), clip_cur(lvl), clip_cur(lvl));
            case ($urandom_range(0, 3))
                0: step = $urandom_range(0, 5);
                1: step = $urandom_range(0, 2000);
                2: step = $urandom_range(0, 40000);
                default: step = 100000;
            endcase
            gen_now = gen_now + 32'(step);
        end
    endtask

    task automatic random_phase(int count);
        int start;
        start = tick_queue.size() + n_ticks;
        while (tick_queue.size() + n_ticks - start < count)
        begin
            if ($urandom_range(0, 9) < 8)
                fault_scenario();
            else
                // noise: any field value, odd resets
                push_tick(($urandom_range(0, 9) == 0) ? OP_RESET : OP_TICK, $urandom,
                          $urandom_range(0, 20'hFFFFF), $urandom_range(0, 20'hFFFFF),
                          $urandom_range(0, 20'hFFFFF));
            // keep the queue short so pressure and settings follow the run
            while (tick_queue.size() > 40)
                @(posedge clk);
        end
    endtask

    initial
    begin
        prot_state = RS_IDLE;
        prot_stage = STG_NONE;
        pickup_t0 = '0;
        trip_held = 1'b0;
        pickup_set = PICKUP_RESET;
        tmult_set = TMULT_RESET;
        gen_pickup = PICKUP_RESET;
        gen_now = 32'd1000;
        hold_tx = 1'b0;
        tick_taken = 1'b0;
        tick_gap = 0;
        rdy_gap = 0;
        idle_cycles = 0;
        n_ticks = 0;
        n_results = 0;
        n_trips = 0;
        n_cfg = 0;
        n_errors = 0;
        @(posedge rst_n);

        // directed: extremes, instantaneous and earth idmt stages, every state, reset op, time wrap
        push_tick(OP_TICK, 32'd0, 20'd0, 20'd0, 20'd0);
        push_tick(OP_TICK, 32'hFFFF_FFFF, CUR_TOP, CUR_TOP, CUR_TOP);
        push_tick(OP_TICK, 32'd10, 20'd4001, 20'd4001, 20'd4001);  // phase instantaneous trip
        push_tick(OP_TICK, 32'd20, 20'd8000, 20'd8000, 20'd8000);  // to lockout
        push_tick(OP_TICK, 32'd30000, 20'd8000, 20'd8000, 20'd8000); // lockout holds
        push_tick(OP_TICK, 32'd30001, 20'd0, 20'd0, 20'd0);        // lockout holds
        push_tick(OP_TICK, 32'd30002, CUR_TOP, 20'd0, 20'd0);      // lockout holds
        push_tick(OP_RESET, 32'hFFFF_FFFF, CUR_TOP, CUR_TOP, CUR_TOP);
        push_tick(OP_TICK, 32'd5, 20'd50000, 20'd50000, 20'd50000); // phase instantaneous
        push_tick(OP_TICK, 32'd5, 20'd0, 20'd0, 20'd0);
        push_tick(OP_RESET, 32'd0, 20'd0, 20'd0, 20'd0);
        push_tick(OP_TICK, 32'd7, 20'd0, 20'd9000, 20'd0);         // earth instantaneous
        push_tick(OP_TICK, 32'd7, 20'd0, 20'd0, 20'd0);
        push_tick(OP_RESET, 32'd0, 20'd0, 20'd0, 20'd0);
        push_tick(OP_TICK, 32'hFFFF_FF00, 20'd1000, 20'd0, 20'd0); // earth idmt, wraps
        push_tick(OP_TICK, 32'h0000_0100, 20'd1000, 20'd0, 20'd0);
        push_tick(OP_TICK, 32'h0010_0000, 20'd1000, 20'd0, 20'd0);
        push_tick(OP_RESET, 32'd0, 20'd0, 20'd0, 20'd0);
        push_tick(OP_TICK, 32'd1, 20'd800, 20'd0, 20'd0);          // earth at threshold
        push_tick(OP_TICK, 32'd2, 20'd4000, 20'd4000, 20'd4000);   // phase at threshold
        push_tick(OP_TICK, 32'd3, CUR_TOP, 20'd0, CUR_TOP);
        random_phase(200);

        // sender waits for every pending result once
        drain();
        hold_tx = 1'b1;
        random_phase(10);
        repeat (300) @(posedge clk);
        hold_tx = 1'b0;
        random_phase(80);

        // lowest nonzero settings
        drain();
        write_reg(REG_PHASE_PICKUP, 20'd1);
        write_reg(REG_TIME_MULT, 20'd1);
        random_phase(150);

        // highest settings
        drain();
        write_reg(REG_PHASE_PICKUP, 20'hFFFFF);
        write_reg(REG_TIME_MULT, 20'h3FFF);
        random_phase(150);

        // zero pickup and zero multiplier
        drain();
        write_reg(REG_PHASE_PICKUP, 20'd0);
        write_reg(REG_TIME_MULT, 20'd0);
        random_phase(100);

        // mid range
        drain();
        write_reg(REG_PHASE_PICKUP, 20'd250);
        write_reg(REG_TIME_MULT, 20'd5000);
        random_phase(200);

        drain();
        write_reg(REG_PHASE_PICKUP, 20'd4000);
        write_reg(REG_TIME_MULT, 20'd50);
        random_phase(200);

        drain();
        $display("covered %0d requests, %0d results, %0d trips, %0d register writes",
                 n_ticks, n_results, n_trips, n_cfg);
        $display("settings from zero to full scale, faults of every stage, %0d errors",
                 n_errors);
        if (n_errors == 0 && relay_expected.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
